[hdl/rrpt_pkg.sv]
// ----------------------------------------------------------------------------
// rrpt_pkg: shared types for the round-robin process table
// Operation, status and entry-state codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrpt_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_FORK  = 3'd1,
        OP_SCHED = 3'd2,
        OP_WAIT  = 3'd3,
        OP_EXIT  = 3'd4
    } rrpt_op_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_FULL       = 3'd1,
        STS_NONE_READY = 3'd2,
        STS_NO_CHILD   = 3'd3,
        STS_INIT       = 3'd4,
        STS_NO_CUR     = 3'd5
    } rrpt_status_t;

    typedef enum logic [1:0] {
        ES_READY      = 2'd0,
        ES_RUNNING    = 2'd1,
        ES_BLOCKED    = 2'd2,
        ES_TERMINATED = 2'd3
    } rrpt_state_t;

    // Table write selection
    typedef enum logic [2:0] {
        WR_NONE,
        WR_APPEND,
        WR_CUR,
        WR_HIT_STATE,
        WR_HIT_WAITS
    } rrpt_wr_t;

    typedef struct packed {
        logic         load;
        logic         rd_cur;
        logic         ld_cur;
        logic         scan_init;
        logic         scan_rd;
        logic         scan_next;
        logic         hit_ld;
        rrpt_wr_t     wr;
        rrpt_state_t  wr_state;
        logic         sched_commit;
        logic         hit_result;
        logic         set_any;
        logic         live_dec;
        logic         set_status;
        rrpt_status_t status;
        logic         finish;
    } rrpt_cmd_t;

    typedef struct packed {
        rrpt_op_t op;
        logic     wait_all;
        logic     full;
        logic     used_zero;
        logic     have_run;
        logic     cur_is_init;
        logic     cur_waits;
        logic     scan_last;
        logic     rd_ready;
        logic     rd_blocked;
        logic     rd_pid_eq;
        logic     rd_parent_me;
        logic     any;
        logic     out_busy;
    } rrpt_sts_t;

endpackage

[hdl/rrpt_dp.sv]
// ----------------------------------------------------------------------------
// rrpt_dp: process table datapath
// Entry memory, counters, current-task registers, scan pointer and the
// output beat register. Acts on controller commands and configuration writes.
// ----------------------------------------------------------------------------
module rrpt_dp
    import rrpt_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int PID_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic [39:0] s_tdata,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [55:0] m_tdata,
    input  rrpt_cmd_t   cmd,
    output rrpt_sts_t   sts
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int LIM_W  = (CNT_W > 7) ? CNT_W : 7;

    typedef struct packed {
        rrpt_state_t         st;
        logic [PID_BITS-1:0] pid;
        logic [PID_BITS-1:0] parent;
        logic [1:0]          prio;
        logic                waits;
    } ent_t;

    ent_t mem [MAX_TASKS];
    ent_t rdata_reg;
    ent_t cur_ent_reg;
    ent_t hit_ent_reg;
    ent_t wr_data;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_addr;

    logic [6:0]          limit_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    live_reg;
    logic [SLOT_W-1:0]   cur_slot_reg;
    logic                cur_valid_reg;
    logic [PID_BITS-1:0] cur_pid_reg;
    logic [PID_BITS-1:0] next_pid_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]   idx_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SLOT_W-1:0]   hit_idx_reg;
    logic                any_reg;
    logic                m_tvalid_reg;
    logic [55:0]         m_tdata_reg;

    logic [2:0]          op_reg;
    logic [PID_BITS-1:0] add_parent_reg;
    logic [1:0]          add_prio_reg;
    logic [PID_BITS-1:0] wait_pid_reg;
    logic                wait_all_reg;

    rrpt_status_t        status_reg;
    logic [SLOT_W-1:0]   slot_res_reg;
    logic [PID_BITS-1:0] rpid_reg;

    logic [LIM_W-1:0]    lim_eff;
    logic [PID_BITS-1:0] key_pid;
    logic [PID_BITS-1:0] app_parent;
    logic [1:0]          app_prio;

    // Wrapping successor of a slot within the used part of the table
    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] used);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W + 1)'(s) + 1'b1;
        return (nxt >= (CNT_W + 1)'(used)) ? '0 : SLOT_W'(nxt);
    endfunction

    always_comb begin
        if (LIM_W'(limit_reg) > LIM_W'(MAX_TASKS)) begin
            lim_eff = LIM_W'(MAX_TASKS);
        end else begin
            lim_eff = LIM_W'(limit_reg);
        end
    end

    assign key_pid    = (op_reg == OP_WAIT) ? wait_pid_reg : cur_ent_reg.parent;
    assign app_parent = (op_reg == OP_ADD) ? add_parent_reg : cur_ent_reg.pid;
    assign app_prio   = (op_reg == OP_ADD) ? add_prio_reg : cur_ent_reg.prio;
    assign rd_addr    = cmd.rd_cur ? cur_slot_reg : idx_reg;
    assign idx_next   = wrap_inc(idx_reg, used_reg);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = hit_idx_reg;
        wr_data = hit_ent_reg;
        case (cmd.wr)
            WR_APPEND: begin
                wr_addr = SLOT_W'(used_reg);
                wr_data = '{st: ES_READY, pid: next_pid_reg, parent: app_parent,
                            prio: (app_prio > 2'd2) ? 2'd2 : app_prio, waits: 1'b0};
            end
            WR_CUR: begin
                wr_addr    = cur_slot_reg;
                wr_data    = cur_ent_reg;
                wr_data.st = cmd.wr_state;
            end
            WR_HIT_STATE: begin
                wr_data.st = cmd.wr_state;
            end
            WR_HIT_WAITS: begin
                wr_data.waits = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_cur || cmd.scan_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_tdata[2:0];
            add_parent_reg <= PID_BITS'(s_tdata[18:3]);
            add_prio_reg   <= s_tdata[20:19];
            wait_pid_reg   <= PID_BITS'(s_tdata[36:21]);
            wait_all_reg   <= s_tdata[37];
            status_reg     <= STS_OK;
            slot_res_reg   <= '0;
            rpid_reg       <= '0;
        end
        if (cmd.ld_cur) begin
            cur_ent_reg <= rdata_reg;
        end else if (cmd.wr == WR_CUR) begin
            cur_ent_reg.st <= cmd.wr_state;
        end else if (cmd.wr == WR_HIT_WAITS && hit_idx_reg == cur_slot_reg) begin
            cur_ent_reg.waits <= 1'b1;
        end
        if (cmd.hit_ld) begin
            hit_ent_reg <= rdata_reg;
            hit_idx_reg <= idx_reg;
        end
        if (cmd.scan_init) begin
            idx_reg <= (op_reg == OP_SCHED && cur_valid_reg)
                       ? wrap_inc(cur_slot_reg, used_reg) : '0;
            cnt_reg <= '0;
        end else if (cmd.scan_next) begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.wr == WR_APPEND) begin
            slot_res_reg <= SLOT_W'(used_reg);
            rpid_reg     <= next_pid_reg;
        end
        if (cmd.sched_commit || cmd.hit_result) begin
            slot_res_reg <= hit_idx_reg;
            rpid_reg     <= hit_ent_reg.pid;
        end
        if (cmd.sched_commit) begin
            cur_pid_reg <= hit_ent_reg.pid;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.finish) begin
            m_tdata_reg <= {1'b0, 7'(used_reg), 7'(live_reg),
                            cur_valid_reg ? 16'(cur_pid_reg) : 16'd0,
                            16'(rpid_reg), 6'(slot_res_reg), status_reg};
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= 7'd64;
            used_reg      <= '0;
            live_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            next_pid_reg  <= PID_BITS'(1);
            any_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.wr == WR_APPEND) begin
                used_reg     <= used_reg + 1'b1;
                live_reg     <= live_reg + 1'b1;
                next_pid_reg <= next_pid_reg + 1'b1;
            end
            if (cmd.live_dec && live_reg != '0) begin
                live_reg <= live_reg - 1'b1;
            end
            if (cmd.sched_commit) begin
                cur_slot_reg  <= hit_idx_reg;
                cur_valid_reg <= 1'b1;
            end
            if (cmd.load) begin
                any_reg <= 1'b0;
            end else if (cmd.set_any) begin
                any_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts.op           = rrpt_op_t'(op_reg);
        sts.wait_all     = wait_all_reg;
        sts.full         = LIM_W'(used_reg) >= lim_eff;
        sts.used_zero    = (used_reg == '0);
        sts.have_run     = cur_valid_reg && (cur_ent_reg.st == ES_RUNNING);
        sts.cur_is_init  = (cur_ent_reg.pid == PID_BITS'(1));
        sts.cur_waits    = cur_ent_reg.waits;
        sts.scan_last    = (cnt_reg == used_reg - 1'b1);
        sts.rd_ready     = (rdata_reg.st == ES_READY);
        sts.rd_blocked   = (rdata_reg.st == ES_BLOCKED);
        sts.rd_pid_eq    = (rdata_reg.pid == key_pid);
        sts.rd_parent_me = (rdata_reg.parent == cur_ent_reg.pid);
        sts.any          = any_reg;
        sts.out_busy     = m_tvalid_reg && !m_tready;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(MAX_TASKS))
        else $error("entry count beyond table depth");
    a_live_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= used_reg)
        else $error("active count above entry count");
    a_cur_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (CNT_W'(cur_slot_reg) < used_reg))
        else $error("current slot outside used entries");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr == WR_APPEND) |-> !sts.full)
        else $error("append into a full table");
`endif

endmodule

[hdl/rrpt_ctrl.sv]
// ----------------------------------------------------------------------------
// rrpt_ctrl: process table controller
// Sequences each operation: current-entry fetch, decision, table scan,
// write-back and result beat.
// ----------------------------------------------------------------------------
module rrpt_ctrl
    import rrpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rrpt_sts_t sts,
    output rrpt_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_LD_CUR,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCHED_HIT,
        S_WAIT_HIT,
        S_WAIT_END,
        S_EXIT_WAKE,
        S_EXIT_END,
        S_FINISH
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.wr     = WR_NONE;
        cmd.status = STS_OK;
        cmd.wr_state = ES_READY;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD_CUR;
                end
            end
            S_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = S_LD_CUR;
            end
            S_LD_CUR: begin
                cmd.ld_cur = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_FINISH;
                case (sts.op)
                    OP_ADD: begin
                        if (sts.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_FULL;
                        end else begin
                            cmd.wr = WR_APPEND;
                        end
                    end
                    OP_FORK: begin
                        cmd.set_status = 1'b1;
                        if (sts.full) begin
                            cmd.status = STS_FULL;
                        end else if (!sts.have_run) begin
                            cmd.status = STS_NO_CUR;
                        end else begin
                            cmd.status = STS_OK;
                            cmd.wr     = WR_APPEND;
                        end
                    end
                    OP_SCHED: begin
                        if (sts.used_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_NONE_READY;
                        end else begin
                            if (sts.have_run) begin
                                cmd.wr       = WR_CUR;
                                cmd.wr_state = ES_READY;
                            end
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                    OP_WAIT: begin
                        if (!sts.have_run) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_NO_CUR;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                    OP_EXIT: begin
                        if (!sts.have_run) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_NO_CUR;
                        end else if (sts.cur_is_init) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_INIT;
                        end else if (sts.cur_waits) begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end else begin
                            state_next = S_EXIT_END;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.hit_ld = 1'b1;
                case (sts.op)
                    OP_SCHED: begin
                        if (sts.rd_ready) begin
                            state_next = S_SCHED_HIT;
                        end else if (sts.scan_last) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_NONE_READY;
                            state_next     = S_FINISH;
                        end else begin
                            cmd.scan_next = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                    OP_WAIT: begin
                        if (sts.wait_all) begin
                            if (sts.rd_parent_me) begin
                                state_next = S_WAIT_HIT;
                            end else if (sts.scan_last) begin
                                state_next = S_WAIT_END;
                            end else begin
                                cmd.scan_next = 1'b1;
                                state_next    = S_SCAN_RD;
                            end
                        end else if (sts.rd_pid_eq) begin
                            state_next = sts.rd_parent_me ? S_WAIT_HIT : S_WAIT_END;
                        end else if (sts.scan_last) begin
                            state_next = S_WAIT_END;
                        end else begin
                            cmd.scan_next = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                    default: begin
                        // exit: look for the parent to wake
                        if (sts.rd_pid_eq) begin
                            state_next = sts.rd_blocked ? S_EXIT_WAKE : S_EXIT_END;
                        end else if (sts.scan_last) begin
                            state_next = S_EXIT_END;
                        end else begin
                            cmd.scan_next = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCHED_HIT: begin
                cmd.wr           = WR_HIT_STATE;
                cmd.wr_state     = ES_RUNNING;
                cmd.sched_commit = 1'b1;
                state_next       = S_FINISH;
            end
            S_WAIT_HIT: begin
                cmd.wr      = WR_HIT_WAITS;
                cmd.set_any = 1'b1;
                if (!sts.wait_all) begin
                    cmd.hit_result = 1'b1;
                    state_next     = S_WAIT_END;
                end else if (sts.scan_last) begin
                    state_next = S_WAIT_END;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_WAIT_END: begin
                if (sts.any) begin
                    cmd.wr       = WR_CUR;
                    cmd.wr_state = ES_BLOCKED;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STS_NO_CHILD;
                end
                state_next = S_FINISH;
            end
            S_EXIT_WAKE: begin
                cmd.wr       = WR_HIT_STATE;
                cmd.wr_state = ES_READY;
                state_next   = S_EXIT_END;
            end
            S_EXIT_END: begin
                cmd.wr       = WR_CUR;
                cmd.wr_state = ES_TERMINATED;
                cmd.live_dec = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !sts.out_busy)
        else $error("result overwrote an untaken beat");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("no return to idle after result");
`endif

endmodule

[hdl/round_robin_process_table.sv]
// ----------------------------------------------------------------------------
// round_robin_process_table: process table with round-robin dispatch
// Add, fork, schedule, waitpid and exit on a table of task entries; one
// result beat per operation.
//
//   channel  | dir | beat fields (low bit first)
//   ---------+-----+---------------------------------------------------------
//   s_       | in  | op, add_parent_pid, add_priority, wait_pid, wait_all
//   m_       | out | status, slot_index, result_pid, current_pid,
//            |     | active_count, task_count
//   cfg_     | in  | task_limit (write only)
//
// Add, fork and ops that fail early pass from accept through current-entry
// read and load, decision and result. Schedule and waitpid walk the used
// entries, as does exit when its task is waited on: a memory read, then a
// compare per entry, plus a table write for each wait-all match.
// Reset clears counters and the current task; the memory is not cleared and
// needs no clearing pass. One item is in work at a time; the next is taken
// once the result sits in the output register, even if m_tready is low.
// ----------------------------------------------------------------------------
module round_robin_process_table
    import rrpt_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int PID_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,     // task_limit
    // operation stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // op[2:0], add_parent_pid[18:3],
                                       // add_priority[20:19], wait_pid[36:21],
                                       // wait_all[37], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata        // status[2:0], slot_index[8:3],
                                       // result_pid[24:9], current_pid[40:25],
                                       // active_count[47:41], task_count[54:48]
);

    rrpt_cmd_t cmd;
    rrpt_sts_t sts;

    // Controller: one operation at a time, hold the result until taken
    rrpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: entry memory, counters and the output beat register
    rrpt_dp #(
        .MAX_TASKS (MAX_TASKS),
        .PID_BITS  (PID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
